/* hdl/pti_pkg.sv */
// Shared constants, types and helper functions of the plane and triangle intersection block.
package pti_pkg;

    localparam int unsigned AXES           = 3;
    localparam int unsigned NUM_VTX        = 3;
    localparam int unsigned MAX_CANDIDATES = 6;
    localparam int unsigned NUM_PAIRS      = MAX_CANDIDATES * (MAX_CANDIDATES - 1) / 2;
    localparam int unsigned NUM_LANES      = NUM_VTX * AXES;
    localparam int unsigned DIV_STEPS      = 32;
    localparam int unsigned LATENCY        = 10 + DIV_STEPS;

    localparam logic [31:0] NORMAL_Y_RESET = 32'h0001_0000;
    localparam logic [15:0] EPSILON_RESET  = 16'd7;

    typedef enum logic [2:0] {
        REG_PLANE_X  = 3'd0,
        REG_PLANE_Y  = 3'd1,
        REG_PLANE_Z  = 3'd2,
        REG_NORMAL_X = 3'd3,
        REG_NORMAL_Y = 3'd4,
        REG_NORMAL_Z = 3'd5,
        REG_EPSILON  = 3'd6
    } reg_idx_t;

    // One 3D point, x in the lowest slot.
    typedef logic [AXES-1:0][31:0] point_t;

    // Triangle data that rides alongside the crossing dividers.
    typedef struct packed {
        point_t [NUM_VTX-1:0] vtx;
        logic   [NUM_VTX-1:0] on_plane;
        logic   [NUM_VTX-1:0] edge_ok;
    } tri_side_t;

    // Floor of the sum divided by 2^16, saturated to signed 32 bits.
    function automatic logic [31:0] sat_dist(input logic [66:0] sum);
        logic [66:0] sh;
        sh = 67'($signed(sum) >>> 16);
        if (sh[66:31] == {36{sh[66]}}) begin
            return sh[31:0];
        end
        return sh[66] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    endfunction

    // Index of the vertex that closes the edge starting at vertex e.
    function automatic int unsigned next_vtx(input int unsigned e);
        return (e == NUM_VTX - 1) ? 0 : e + 1;
    endfunction

    // Linear index of the candidate pair (i, j) with i < j.
    function automatic int unsigned pair_index(input int unsigned i, input int unsigned j);
        return i * MAX_CANDIDATES - (i * (i + 1)) / 2 + (j - i - 1);
    endfunction

endpackage

/* hdl/pti_div.sv */
// Pipelined restoring divider lane, one quotient bit per register stage.
module pti_div (
    input  logic        clk,
    input  logic [63:0] dividend,
    input  logic [31:0] divisor,
    input  logic        neg,
    output logic [31:0] quotient,
    output logic        quo_neg
);

    localparam int unsigned STEPS = pti_pkg::DIV_STEPS;

    // The caller must keep dividend < divisor * 2^32; then the quotient fits 32 bits.
    logic [31:0]      rem_reg [STEPS-1];
    logic [31:0]      dvs_reg [STEPS-1];
    logic [31:0]      low_reg [STEPS];
    logic             neg_reg [STEPS];

    for (genvar s = 0; s < STEPS; s++) begin : g_step
        logic [31:0] rem_in;
        logic [31:0] low_in;
        logic [31:0] dvs_in;
        logic        neg_in;
        logic [32:0] trial;
        logic        ge;

        if (s == 0) begin : g_first
            assign rem_in = dividend[63:32];
            assign low_in = dividend[31:0];
            assign dvs_in = divisor;
            assign neg_in = neg;
        end else begin : g_next
            assign rem_in = rem_reg[s-1];
            assign low_in = low_reg[s-1];
            assign dvs_in = dvs_reg[s-1];
            assign neg_in = neg_reg[s-1];
        end

        assign trial = {rem_in, low_in[31]};
        assign ge    = (trial >= {1'b0, dvs_in});

        always_ff @(posedge clk)
        begin
            low_reg[s] <= {low_in[30:0], ge};
            neg_reg[s] <= neg_in;
        end

        if (s < STEPS - 1) begin : g_carry
            always_ff @(posedge clk)
            begin
                rem_reg[s] <= ge ? 32'(trial - {1'b0, dvs_in}) : trial[31:0];
                dvs_reg[s] <= dvs_in;
            end
        end
    end

    assign quotient = low_reg[STEPS-1];
    assign quo_neg  = neg_reg[STEPS-1];

endmodule

/* hdl/plane_triangle_intersection.sv */
// Top level of the plane and triangle intersection pipeline.
//
//  channel   signals                               transaction
//  -------   ------------------------------------  ---------------------------------------
//  input     start, busy, a_x .. c_z               start high and busy low at a clock edge
//  result    done, hit, start_x .. end_z           done high for one cycle, always taken
//  config    cfg_we, cfg_index, cfg_wdata          cfg_we high at a clock edge
//
// One triangle can be taken every cycle; busy is always low. Each result appears at
// the end of the pipeline, whose depth is set mostly by the 32-stage restoring
// dividers that place the edge crossing points. Reset clears the valid pipeline
// and loads the register defaults; payload flops are not reset. The receiver
// cannot stall, so the pipeline never holds.
module plane_triangle_intersection (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] a_x,
    input  logic signed [31:0] a_y,
    input  logic signed [31:0] a_z,
    input  logic signed [31:0] b_x,
    input  logic signed [31:0] b_y,
    input  logic signed [31:0] b_z,
    input  logic signed [31:0] c_x,
    input  logic signed [31:0] c_y,
    input  logic signed [31:0] c_z,
    output logic               done,
    output logic               hit,
    output logic signed [31:0] start_x,
    output logic signed [31:0] start_y,
    output logic signed [31:0] start_z,
    output logic signed [31:0] end_x,
    output logic signed [31:0] end_y,
    output logic signed [31:0] end_z,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_wdata
);

    localparam int unsigned NV    = pti_pkg::NUM_VTX;
    localparam int unsigned NA    = pti_pkg::AXES;
    localparam int unsigned NC    = pti_pkg::MAX_CANDIDATES;
    localparam int unsigned NP    = pti_pkg::NUM_PAIRS;
    localparam int unsigned NL    = pti_pkg::NUM_LANES;
    localparam int unsigned STEPS = pti_pkg::DIV_STEPS;
    localparam int unsigned LAT   = pti_pkg::LATENCY;

    // ------------------------------------------------------------------
    // Configuration registers. Write only while the pipeline is empty; not enforced.
    // ------------------------------------------------------------------
    logic signed [31:0] pp_reg  [NA];
    logic signed [31:0] nrm_reg [NA];
    logic [15:0]        eps_reg;
    logic [31:0]        eps_sq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pp_reg[0]  <= '0;
            pp_reg[1]  <= '0;
            pp_reg[2]  <= '0;
            nrm_reg[0] <= '0;
            nrm_reg[1] <= pti_pkg::NORMAL_Y_RESET;
            nrm_reg[2] <= '0;
            eps_reg    <= pti_pkg::EPSILON_RESET;
        end
        else if (cfg_we)
        begin
            unique case (pti_pkg::reg_idx_t'(cfg_index))
                pti_pkg::REG_PLANE_X:  pp_reg[0]  <= cfg_wdata;
                pti_pkg::REG_PLANE_Y:  pp_reg[1]  <= cfg_wdata;
                pti_pkg::REG_PLANE_Z:  pp_reg[2]  <= cfg_wdata;
                pti_pkg::REG_NORMAL_X: nrm_reg[0] <= cfg_wdata;
                pti_pkg::REG_NORMAL_Y: nrm_reg[1] <= cfg_wdata;
                pti_pkg::REG_NORMAL_Z: nrm_reg[2] <= cfg_wdata;
                pti_pkg::REG_EPSILON:  eps_reg    <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // The squared tolerance for the duplicate test follows epsilon in the next cycle.
    always_ff @(posedge clk)
    begin
        eps_sq_reg <= 32'(eps_reg) * 32'(eps_reg);
    end

    // ------------------------------------------------------------------
    // Valid bits: one per stage, shifting every cycle.
    // ------------------------------------------------------------------
    logic [LAT-1:0] vld_reg;
    logic           accept;

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[LAT-2:0], accept};
        end
    end

    // ------------------------------------------------------------------
    // Stage A: capture the vertices and their offsets from the plane point.
    // ------------------------------------------------------------------
    pti_pkg::point_t    in_vtx [NV];
    pti_pkg::point_t    a_vtx_reg  [NV];
    logic signed [32:0] a_diff_reg [NV][NA];

    assign in_vtx[0] = {a_z, a_y, a_x};
    assign in_vtx[1] = {b_z, b_y, b_x};
    assign in_vtx[2] = {c_z, c_y, c_x};

    always_ff @(posedge clk)
    begin
        for (int v = 0; v < NV; v++)
        begin
            a_vtx_reg[v] <= in_vtx[v];
            for (int k = 0; k < NA; k++)
            begin
                a_diff_reg[v][k] <= 33'($signed(in_vtx[v][k])) - 33'(pp_reg[k]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage B: offset times normal, exact Q32.32 products.
    // ------------------------------------------------------------------
    pti_pkg::point_t    b_vtx_reg  [NV];
    logic signed [64:0] b_prod_reg [NV][NA];

    always_ff @(posedge clk)
    begin
        for (int v = 0; v < NV; v++)
        begin
            b_vtx_reg[v] <= a_vtx_reg[v];
            for (int k = 0; k < NA; k++)
            begin
                b_prod_reg[v][k] <= 65'(a_diff_reg[v][k]) * 65'(nrm_reg[k]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage C: signed distances (floored to Q16.16, saturated) and edge vectors.
    // ------------------------------------------------------------------
    pti_pkg::point_t    c_vtx_reg [NV];
    logic signed [31:0] c_d_reg   [NV];
    logic signed [32:0] c_ev_reg  [NV][NA];

    always_ff @(posedge clk)
    begin
        for (int v = 0; v < NV; v++)
        begin
            c_vtx_reg[v] <= b_vtx_reg[v];
            c_d_reg[v]   <= pti_pkg::sat_dist(67'(b_prod_reg[v][0]) + 67'(b_prod_reg[v][1])
                                              + 67'(b_prod_reg[v][2]));
            for (int k = 0; k < NA; k++)
            begin
                c_ev_reg[v][k] <= 33'($signed(b_vtx_reg[pti_pkg::next_vtx(v)][k]))
                                  - 33'($signed(b_vtx_reg[v][k]));
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage D: on-plane tests, edge screening, gate and crossing numerators.
    // Edge e runs from vertex e to the next vertex.
    // ------------------------------------------------------------------
    logic [31:0]        d_mag   [NV];
    logic signed [32:0] dlt     [NV];
    logic [32:0]        dlt_mag [NV];
    logic [NV-1:0]      d_pos;
    logic [NV-1:0]      d_neg;
    logic [NV-1:0]      onp;
    logic [NV-1:0]      cross_ok;
    logic               early;

    always_comb
    begin
        for (int v = 0; v < NV; v++)
        begin
            d_mag[v]   = c_d_reg[v][31] ? (~c_d_reg[v] + 32'd1) : c_d_reg[v];
            dlt[v]     = 33'(c_d_reg[v]) - 33'(c_d_reg[pti_pkg::next_vtx(v)]);
            dlt_mag[v] = dlt[v][32] ? (~dlt[v] + 33'd1) : dlt[v];
            d_pos[v]   = !c_d_reg[v][31] && (c_d_reg[v] != '0);
            d_neg[v]   = c_d_reg[v][31];
            onp[v]     = d_mag[v] < 32'(eps_reg);
            // Skip a nearly parallel edge, and one whose crossing falls outside it.
            cross_ok[v] = !((dlt_mag[v][31:0] < 32'(eps_reg)) || (dlt[v] == '0)
                            || ((c_d_reg[v] != '0)
                                && ((c_d_reg[v][31] != dlt[v][32])
                                    || (d_mag[v] > dlt_mag[v][31:0]))));
        end
        // All three vertices strictly on one side: nothing to report.
        early = (&d_pos) | (&d_neg);
    end

    pti_pkg::point_t    d_vtx_reg  [NV];
    logic signed [63:0] d_gate_reg [NV];
    logic signed [64:0] d_num_reg  [NV][NA];
    logic [31:0]        d_dmag_reg [NV];
    logic [NV-1:0]      d_dneg_reg;
    logic [NV-1:0]      d_cok_reg;
    logic [NV-1:0]      d_onp_reg;
    logic               d_early_reg;

    always_ff @(posedge clk)
    begin
        for (int v = 0; v < NV; v++)
        begin
            d_vtx_reg[v]  <= c_vtx_reg[v];
            d_gate_reg[v] <= 64'(c_d_reg[v]) * 64'(c_d_reg[pti_pkg::next_vtx(v)]);
            d_dmag_reg[v] <= dlt_mag[v][31:0];
            d_dneg_reg[v] <= dlt[v][32];
            d_cok_reg[v]  <= cross_ok[v];
            d_onp_reg[v]  <= onp[v] & ~early;
            for (int k = 0; k < NA; k++)
            begin
                d_num_reg[v][k] <= 65'(c_ev_reg[v][k]) * 65'(c_d_reg[v]);
            end
        end
        d_early_reg <= early;
    end

    // ------------------------------------------------------------------
    // Stage E: apply the product gate and set up the divider lanes.
    // Lane e*3+k divides axis k of edge e.
    // ------------------------------------------------------------------
    pti_pkg::tri_side_t e_side_reg;
    logic [63:0]        e_num_reg [NL];
    logic [31:0]        e_dvs_reg [NL];
    logic [NL-1:0]      e_neg_reg;

    always_ff @(posedge clk)
    begin
        for (int v = 0; v < NV; v++)
        begin
            e_side_reg.vtx[v]      <= d_vtx_reg[v];
            e_side_reg.on_plane[v] <= d_onp_reg[v];
            e_side_reg.edge_ok[v]  <= d_cok_reg[v] & ~d_early_reg
                                      & (d_gate_reg[v] < $signed({32'd0, eps_reg, 16'd0}));
            for (int k = 0; k < NA; k++)
            begin
                e_num_reg[v*NA + k] <= d_num_reg[v][k][64] ? 64'(-d_num_reg[v][k])
                                                           : d_num_reg[v][k][63:0];
                e_dvs_reg[v*NA + k] <= d_dmag_reg[v];
                e_neg_reg[v*NA + k] <= d_num_reg[v][k][64] ^ d_dneg_reg[v];
            end
        end
    end

    // ------------------------------------------------------------------
    // Divider section: nine lanes, truncating quotients, with the triangle
    // data delayed alongside.
    // ------------------------------------------------------------------
    logic [31:0]        quo [NL];
    logic [NL-1:0]      quo_neg;
    pti_pkg::tri_side_t side_pipe_reg [STEPS];

    for (genvar l = 0; l < NL; l++) begin : g_lane
        pti_div u_div (
            .clk      (clk),
            .dividend (e_num_reg[l]),
            .divisor  (e_dvs_reg[l]),
            .neg      (e_neg_reg[l]),
            .quotient (quo[l]),
            .quo_neg  (quo_neg[l])
        );
    end

    always_ff @(posedge clk)
    begin
        side_pipe_reg[0] <= e_side_reg;
        for (int s = 1; s < STEPS; s++)
        begin
            side_pipe_reg[s] <= side_pipe_reg[s-1];
        end
    end

    // ------------------------------------------------------------------
    // Stage F: candidate list in model order: vertex 0, edge 0, vertex 1, ...
    // ------------------------------------------------------------------
    pti_pkg::tri_side_t f_side;
    pti_pkg::point_t    cross_pt [NV];
    logic [32:0]        qs;

    always_comb
    begin
        f_side = side_pipe_reg[STEPS-1];
        qs     = '0;
        for (int v = 0; v < NV; v++)
        begin
            for (int k = 0; k < NA; k++)
            begin
                qs = {1'b0, quo[v*NA + k]};
                if (quo_neg[v*NA + k])
                begin
                    qs = ~qs + 33'd1;
                end
                cross_pt[v][k] = 32'({f_side.vtx[v][k][31], f_side.vtx[v][k]} + qs);
            end
        end
    end

    pti_pkg::point_t cand_pipe_reg [4][NC];
    logic [NC-1:0]   cval_pipe_reg [4];

    always_ff @(posedge clk)
    begin
        for (int v = 0; v < NV; v++)
        begin
            cand_pipe_reg[0][2*v]     <= f_side.vtx[v];
            cand_pipe_reg[0][2*v + 1] <= cross_pt[v];
            cval_pipe_reg[0][2*v]     <= f_side.on_plane[v];
            cval_pipe_reg[0][2*v + 1] <= f_side.edge_ok[v];
        end
        for (int s = 1; s < 4; s++)
        begin
            cand_pipe_reg[s] <= cand_pipe_reg[s-1];
            cval_pipe_reg[s] <= cval_pipe_reg[s-1];
        end
    end

    // ------------------------------------------------------------------
    // Stages G, H, I: pairwise overlap test. A pair overlaps when every axis
    // differs by less than epsilon and the squared distance is below epsilon^2.
    // ------------------------------------------------------------------
    logic [NA-1:0][15:0] g_lo_reg [NP];
    logic [NA-1:0]       g_lt_reg [NP];
    logic [NA-1:0][31:0] h_sq_reg [NP];
    logic                h_near_reg [NP];
    logic                i_ov_reg [NP];
    logic [NC-1:0]       ov_mat [NC];

    for (genvar gi = 0; gi < NC; gi++) begin : g_pi
        for (genvar gj = 0; gj < NC; gj++) begin : g_pj
            if (gj > gi) begin : g_pair
                localparam int unsigned P = pti_pkg::pair_index(gi, gj);
                logic [32:0] df  [NA];
                logic [32:0] mag [NA];

                always_comb
                begin
                    for (int k = 0; k < NA; k++)
                    begin
                        df[k]  = {cand_pipe_reg[0][gi][k][31], cand_pipe_reg[0][gi][k]}
                                 - {cand_pipe_reg[0][gj][k][31], cand_pipe_reg[0][gj][k]};
                        mag[k] = df[k][32] ? (~df[k] + 33'd1) : df[k];
                    end
                end

                always_ff @(posedge clk)
                begin
                    for (int k = 0; k < NA; k++)
                    begin
                        g_lo_reg[P][k] <= mag[k][15:0];
                        g_lt_reg[P][k] <= mag[k][31:0] < 32'(eps_reg);
                        h_sq_reg[P][k] <= 32'(g_lo_reg[P][k]) * 32'(g_lo_reg[P][k]);
                    end
                    h_near_reg[P] <= &g_lt_reg[P];
                    i_ov_reg[P]   <= h_near_reg[P]
                                     && ((34'(h_sq_reg[P][0]) + 34'(h_sq_reg[P][1])
                                          + 34'(h_sq_reg[P][2])) < 34'(eps_sq_reg));
                end

                assign ov_mat[gi][gj] = i_ov_reg[P];
            end else begin : g_none
                assign ov_mat[gi][gj] = 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage J: keep each valid candidate that overlaps no earlier kept one, then
    // report a hit when exactly two remain.
    // ------------------------------------------------------------------
    logic [NC-1:0]   keep;
    logic            dup;
    logic [2:0]      n_keep;
    pti_pkg::point_t first_pt;
    pti_pkg::point_t second_pt;
    logic            hit_next;

    always_comb
    begin
        keep      = '0;
        dup       = 1'b0;
        n_keep    = '0;
        first_pt  = '0;
        second_pt = '0;
        for (int i = 0; i < NC; i++)
        begin
            dup = 1'b0;
            for (int j = 0; j < i; j++)
            begin
                dup = dup | (keep[j] & ov_mat[j][i]);
            end
            keep[i] = cval_pipe_reg[3][i] & ~dup;
        end
        for (int i = 0; i < NC; i++)
        begin
            if (keep[i])
            begin
                if (n_keep == 3'd0)
                begin
                    first_pt = cand_pipe_reg[3][i];
                end
                else if (n_keep == 3'd1)
                begin
                    second_pt = cand_pipe_reg[3][i];
                end
                n_keep = n_keep + 3'd1;
            end
        end
        hit_next = (n_keep == 3'd2);
    end

    logic            out_hit_reg;
    pti_pkg::point_t out_start_reg;
    pti_pkg::point_t out_end_reg;

    always_ff @(posedge clk)
    begin
        out_hit_reg   <= hit_next;
        out_start_reg <= hit_next ? first_pt : '0;
        out_end_reg   <= hit_next ? second_pt : '0;
    end

    assign done    = vld_reg[LAT-1];
    assign hit     = out_hit_reg;
    assign start_x = out_start_reg[0];
    assign start_y = out_start_reg[1];
    assign start_z = out_start_reg[2];
    assign end_x   = out_end_reg[0];
    assign end_y   = out_end_reg[1];
    assign end_z   = out_end_reg[2];

`ifndef ASSERT_OFF
    // Every accepted transaction is followed by the done pulse of its result.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LAT done)
        else $error("result did not follow the accepted transaction at the fixed latency");

    // A miss carries an all-zero segment.
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !hit) |-> (start_x == '0 && start_y == '0 && start_z == '0
                            && end_x == '0 && end_y == '0 && end_z == '0))
        else $error("segment ends not cleared on a miss");

    // With a nonzero tolerance the two kept ends can never be the same point.
    a_distinct_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (done && hit && eps_reg != '0) |-> (start_x != end_x || start_y != end_y
                                             || start_z != end_z))
        else $error("hit reported with coincident segment ends");
`endif

endmodule
